// File: src/toggle_set_running_median_macros.svh
// assertion macros shared by the toggle-set running median modules
`ifndef TOGGLE_SET_RUNNING_MEDIAN_MACROS_SVH
`define TOGGLE_SET_RUNNING_MEDIAN_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define TSRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, clocked on clk, off during reset
`define TSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSRM_ASSERT_NOW(lbl, ante, cons, msg)
`define TSRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/tsrm_pkg.sv
// shared types and constants for the toggle-set running median
package tsrm_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic OP_TOGGLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_RM_RD,
        S_RM_WR,
        S_INS_RD,
        S_INS_WR,
        S_Q_SECOND,
        S_Q_LAST,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SRCH_RD,
        CMD_SRCH_UPD,
        CMD_RM_INIT,
        CMD_RM_RD,
        CMD_RM_WR,
        CMD_RM_END,
        CMD_INS_INIT,
        CMD_INS_RD,
        CMD_INS_WR,
        CMD_INS_PUT,
        CMD_OVER,
        CMD_Q_RD_FIRST,
        CMD_Q_RD_MID,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic query;
        logic n_zero;
        logic n_odd;
        logic search_done;
        logic found;
        logic full;
        logic rm_done;
        logic ins_done;
    } dp_status_t;

endpackage

// File: src/tsrm_ctrl.sv
// controller state machine sequencing search, shift and query steps
`include "toggle_set_running_median_macros.svh"
module tsrm_ctrl
    import tsrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!status.query)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (status.n_zero)
                begin
                    state_next = S_EMIT;
                end
                else if (status.n_odd)
                begin
                    state_next = S_Q_LAST;
                end
                else
                begin
                    state_next = S_Q_SECOND;
                end
            end
            S_SRCH_RD:
            begin
                state_next = status.search_done ? S_DECIDE : S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                state_next = S_SRCH_RD;
            end
            S_DECIDE:
            begin
                if (status.found)
                begin
                    state_next = S_RM_RD;
                end
                else if (status.full)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_RM_RD:
            begin
                state_next = status.rm_done ? S_EMIT : S_RM_WR;
            end
            S_RM_WR:
            begin
                state_next = S_RM_RD;
            end
            S_INS_RD:
            begin
                state_next = status.ins_done ? S_EMIT : S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_INS_RD;
            end
            S_Q_SECOND:
            begin
                state_next = S_Q_LAST;
            end
            S_Q_LAST:
            begin
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = CMD_NONE;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd = CMD_LOAD;
                end
            end
            S_DISPATCH:
            begin
                if (status.query && !status.n_zero)
                begin
                    cmd = status.n_odd ? CMD_Q_RD_MID : CMD_Q_RD_FIRST;
                end
            end
            S_SRCH_RD:
            begin
                if (!status.search_done)
                begin
                    cmd = CMD_SRCH_RD;
                end
            end
            S_SRCH_CMP:
            begin
                cmd = CMD_SRCH_UPD;
            end
            S_DECIDE:
            begin
                if (status.found)
                begin
                    cmd = CMD_RM_INIT;
                end
                else if (status.full)
                begin
                    cmd = CMD_OVER;
                end
                else
                begin
                    cmd = CMD_INS_INIT;
                end
            end
            S_RM_RD:
            begin
                cmd = status.rm_done ? CMD_RM_END : CMD_RM_RD;
            end
            S_RM_WR:
            begin
                cmd = CMD_RM_WR;
            end
            S_INS_RD:
            begin
                cmd = status.ins_done ? CMD_INS_PUT : CMD_INS_RD;
            end
            S_INS_WR:
            begin
                cmd = CMD_INS_WR;
            end
            S_Q_SECOND:
            begin
                cmd = CMD_Q_RD_MID;
            end
            S_Q_LAST:
            begin
                cmd = CMD_EMIT;
            end
            S_EMIT:
            begin
                cmd = CMD_EMIT;
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase
    end

    `TSRM_ASSERT_NEXT(a_start_dispatch, start && !busy, state_reg == S_DISPATCH, "accepted beat not dispatched")
    `TSRM_ASSERT_NEXT(a_emit_idle, cmd == CMD_EMIT, state_reg == S_IDLE, "no return to idle after result")
    `TSRM_ASSERT_NOW(a_put_not_full, cmd == CMD_INS_PUT, !status.full, "insert into full set")

endmodule

// File: src/tsrm_dp.sv
// datapath: sorted value memory, search bounds, shift pointer and result registers
`include "toggle_set_running_median_macros.svh"
module tsrm_dp
    import tsrm_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cmd_t                               cmd,
    input  logic                               op,
    input  logic signed [VALUE_BITS-1:0]       value,
    output dp_status_t                         status,
    output logic                               done,
    output logic signed [VALUE_BITS:0]         twice_median,
    output logic                               set_empty,
    output logic                               was_removed,
    output logic                               overflow,
    output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_BITS-1:0] mem [CAPACITY];

    logic signed [VALUE_BITS-1:0] x_reg;
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] first_reg;
    logic                         op_reg;
    logic [CW-1:0]                lo_reg;
    logic [CW-1:0]                hi_reg;
    logic [CW-1:0]                n_reg;
    logic [CW-1:0]                ptr_reg;
    logic                         found_reg;
    logic                         over_reg;

    logic                         done_reg;
    logic signed [VALUE_BITS:0]   twice_reg;
    logic                         empty_reg;
    logic                         removed_reg;
    logic                         overflow_reg;
    logic [CW-1:0]                count_reg;

    logic [CW:0]                  mid_sum;
    logic [AW-1:0]                mid;
    logic [CW-1:0]                mid_cw;
    logic [CW-1:0]                n_half;
    logic [CW-1:0]                half_m1;
    logic [CW-1:0]                ptr_p1;
    logic [CW-1:0]                ptr_m1;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic signed [VALUE_BITS:0]   med_sum;
    logic                         is_query;
    logic [2:0]                   flags;

    // binary search midpoint, always below hi so it fits the address
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];
    assign mid_cw  = CW'(mid);
    assign n_half  = n_reg >> 1;
    assign half_m1 = n_half - CW'(1);
    assign ptr_p1  = ptr_reg + CW'(1);
    assign ptr_m1  = ptr_reg - CW'(1);

    assign is_query = (op_reg == OP_QUERY);
    assign med_sum  = {rd_data_reg[VALUE_BITS-1], rd_data_reg}
                    + (n_reg[0] ? {rd_data_reg[VALUE_BITS-1], rd_data_reg}
                                : {first_reg[VALUE_BITS-1], first_reg});

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        unique case (cmd)
            CMD_SRCH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            CMD_RM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_p1[AW-1:0];
            end
            CMD_INS_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_m1[AW-1:0];
            end
            CMD_Q_RD_FIRST:
            begin
                rd_en   = 1'b1;
                rd_addr = half_m1[AW-1:0];
            end
            CMD_Q_RD_MID:
            begin
                rd_en   = 1'b1;
                rd_addr = n_half[AW-1:0];
            end
            CMD_RM_WR, CMD_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[AW-1:0];
            end
            CMD_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[AW-1:0];
                wr_data = x_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // sorted value store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd == CMD_EMIT);
            if (cmd == CMD_RM_END)
            begin
                n_reg <= n_reg - CW'(1);
            end
            else if (cmd == CMD_INS_PUT)
            begin
                n_reg <= n_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                x_reg     <= value;
                op_reg    <= op;
                lo_reg    <= '0;
                hi_reg    <= n_reg;
                found_reg <= 1'b0;
                over_reg  <= 1'b0;
            end
            CMD_SRCH_UPD:
            begin
                if (rd_data_reg < x_reg)
                begin
                    lo_reg <= mid_cw + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_cw;
                end
                if (rd_data_reg == x_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            CMD_RM_INIT:
            begin
                ptr_reg <= lo_reg;
            end
            CMD_RM_WR:
            begin
                ptr_reg <= ptr_p1;
            end
            CMD_INS_INIT:
            begin
                ptr_reg <= n_reg;
            end
            CMD_INS_WR:
            begin
                ptr_reg <= ptr_m1;
            end
            CMD_OVER:
            begin
                over_reg <= 1'b1;
            end
            CMD_Q_RD_MID:
            begin
                first_reg <= rd_data_reg;
            end
            CMD_EMIT:
            begin
                twice_reg    <= (is_query && (n_reg != '0)) ? med_sum : '0;
                empty_reg    <= is_query && (n_reg == '0);
                removed_reg  <= !is_query && found_reg;
                overflow_reg <= !is_query && over_reg;
                count_reg    <= n_reg;
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    assign status.query       = is_query;
    assign status.n_zero      = (n_reg == '0);
    assign status.n_odd       = n_reg[0];
    assign status.search_done = (lo_reg >= hi_reg);
    assign status.found       = found_reg;
    assign status.full        = (n_reg == CW'(CAPACITY));
    assign status.rm_done     = ({1'b0, ptr_reg} + (CW+1)'(1)) >= {1'b0, n_reg};
    assign status.ins_done    = (ptr_reg <= lo_reg);

    assign done         = done_reg;
    assign twice_median = twice_reg;
    assign set_empty    = empty_reg;
    assign was_removed  = removed_reg;
    assign overflow     = overflow_reg;
    assign entry_count  = count_reg;

    assign flags = {empty_reg, removed_reg, overflow_reg};

    `TSRM_ASSERT_NOW(a_wr_in_range, wr_en, CW'(wr_addr) <= n_reg, "store write beyond held entries")
    `TSRM_ASSERT_NOW(a_put_room, cmd == CMD_INS_PUT, n_reg != CW'(CAPACITY), "count passes capacity")
    `TSRM_ASSERT_NOW(a_rm_nonempty, cmd == CMD_RM_END, n_reg != '0, "removal from empty set")
    `TSRM_ASSERT_NOW(a_flags_excl, done_reg, $onehot0(flags), "more than one result flag set")

endmodule

// File: src/toggle_set_running_median.sv
// top level of the toggle-set running median: controller plus datapath
//
//  channel   direction  handshake                 payload
//  command   in         start, busy (accept when  op, value
//                       start high, busy low)
//  result    out        done (one-cycle strobe)   twice_median, set_empty,
//                                                 was_removed, overflow,
//                                                 entry_count
//
// one command beat at a time; busy stays high until its result is issued
// query: an empty set skips the store reads; an odd count reads the middle entry, an even count both middles
// toggle: s binary search steps (at most log2(count)+1), then m entries shifted in the store;
//   a dropped insert skips the shift
// with the registered store read, a probe is a read and a compare step, a move a read and a write step
// reset empties the set at once (count cleared, store contents left as is)
// the result strobe cannot be stalled; a new beat may be accepted as it fires
module toggle_set_running_median
    import tsrm_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          done,
    output logic signed [VALUE_BITS:0]    twice_median,
    output logic                          set_empty,
    output logic                          was_removed,
    output logic                          overflow,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

    // command and status between the two halves
    cmd_t       cmd;
    dp_status_t status;

    // sequencer: search, shift and query steps
    tsrm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // value store and arithmetic
    tsrm_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (op),
        .value        (value),
        .status       (status),
        .done         (done),
        .twice_median (twice_median),
        .set_empty    (set_empty),
        .was_removed  (was_removed),
        .overflow     (overflow),
        .entry_count  (entry_count)
    );

endmodule

// File: tb/sv/toggle_set_running_median_tb.sv
// self-checking testbench for the toggle-set running median block
module toggle_set_running_median_tb
    import tsrm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_BITS  = $clog2(CAPACITY_DEF + 1);
    localparam int VAL_MIN   = 32'h8000_0000;
    localparam int VAL_MAX   = 32'h7fff_ffff;
    localparam int QUIET_LO  = 250;   // accepted-beat window with no idling on the command side
    localparam int QUIET_HI  = 350;
    localparam int IDLE_PCT  = 12;
    localparam int TAIL_CYC  = 20;

    // one command beat as the sender sees it
    typedef struct packed {
        logic                             op;
        logic signed [VALUE_BITS_DEF-1:0] value;
    } median_cmd_t;

    // one result beat, laid out like the result ports
    typedef struct packed {
        logic signed [VALUE_BITS_DEF:0] twice_median;
        logic                           set_empty;
        logic                           was_removed;
        logic                           overflow;
        logic [CNT_BITS-1:0]            entry_count;
    } median_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             op = OP_TOGGLE;
    logic signed [VALUE_BITS_DEF-1:0] value = '0;
    logic                             busy;
    logic                             done;
    logic signed [VALUE_BITS_DEF:0]   twice_median;
    logic                             set_empty;
    logic                             was_removed;
    logic                             overflow;
    logic [CNT_BITS-1:0]              entry_count;

    // stimulus side
    median_cmd_t    cmd_backlog[$];
    median_cmd_t    next_cmd;
    int             total_beats = 0;
    int             accepted_count = 0;
    bit             gen_member[int];   // what the generator believes is in the set
    int             gen_list[$];

    // prediction side
    int             median_members[$];  // ascending, distinct
    median_result_t awaited_results[$];
    median_result_t seen_result;
    median_result_t want_result;

    // scoreboard and coverage tallies
    int             err_count = 0;
    int             result_count = 0;
    int             empty_count = 0;
    int             removed_count = 0;
    int             overflow_count = 0;
    int             peak_fill = 0;

    toggle_set_running_median dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .value        (value),
        .done         (done),
        .twice_median (twice_median),
        .set_empty    (set_empty),
        .was_removed  (was_removed),
        .overflow     (overflow),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: sorted set of distinct values, one result per beat
    // ------------------------------------------------------------------
    task automatic update_median_set(input logic op_bit, input int v);
        median_result_t r;
        int             pos;
        int             n;
        int             a;
        int             b;
        r = '0;
        n = median_members.size();
        if (op_bit == OP_TOGGLE)
        begin
            pos = 0;
            while (pos < n && median_members[pos] < v)
                pos++;
            if (pos < n && median_members[pos] == v)
            begin
                // present: remove, always allowed even when full
                median_members.delete(pos);
                r.was_removed = 1'b1;
            end
            else if (n >= CAPACITY_DEF)
                r.overflow = 1'b1;   // full: insert dropped, set unchanged
            else
                median_members.insert(pos, v);
        end
        else
        begin
            if (n == 0)
                r.set_empty = 1'b1;
            else if (n % 2 == 1)
            begin
                a = median_members[n / 2];
                r.twice_median = {a, 1'b0};
            end
            else
            begin
                // sign-extend both middles to 33 bits so the sum is exact
                a = median_members[n / 2 - 1];
                b = median_members[n / 2];
                r.twice_median = {a[31], a} + {b[31], b};
            end
        end
        r.entry_count = CNT_BITS'(median_members.size());
        awaited_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers: the generator tracks membership so it can aim
    // at removals, a full set and dropped inserts
    // ------------------------------------------------------------------
    task automatic add_toggle(input int v);
        median_cmd_t c;
        int          i;
        c.op    = OP_TOGGLE;
        c.value = v;
        cmd_backlog.push_back(c);
        total_beats++;
        if (gen_member.exists(v))
        begin
            gen_member.delete(v);
            for (i = 0; i < gen_list.size(); i++)
                if (gen_list[i] == v)
                begin
                    gen_list.delete(i);
                    break;
                end
        end
        else if (gen_member.num() < CAPACITY_DEF)
        begin
            gen_member[v] = 1'b1;
            gen_list.push_back(v);
        end
    endtask

    // value bits are don't-care for a query, so randomize them anyway
    task automatic add_query();
        median_cmd_t c;
        c.op    = OP_QUERY;
        c.value = $urandom;
        cmd_backlog.push_back(c);
        total_beats++;
    endtask

    function automatic int pick_member();
        if (gen_list.size() == 0)
            return $urandom;
        return gen_list[$urandom_range(gen_list.size() - 1)];
    endfunction

    function automatic int pick_absent();
        int v;
        v = $urandom;
        while (gen_member.exists(v))
            v = $urandom;
        return v;
    endfunction

    // mix of a narrow band (lots of hits), full-range words and extremes
    function automatic int pick_value();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = int'($urandom_range(40)) - 20;
            5, 6, 7:       v = $urandom;
            8:
            begin
                case ($urandom_range(3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = VAL_MIN + 1;
                    default: v = VAL_MAX - 1;
                endcase
            end
            default:       v = pick_member();
        endcase
        return v;
    endfunction

    task automatic build_stimulus();
        int i;
        int v;
        // directed: empty query, lone extremes, odd and even counts,
        // half-integer median, removal back to empty
        add_query();
        add_query();
        add_toggle(VAL_MIN);
        add_query();                 // lowest doubled median
        add_toggle(VAL_MIN);         // remove the only value
        add_toggle(VAL_MAX);
        add_query();                 // highest doubled median
        add_toggle(VAL_MIN);
        add_query();                 // min plus max
        add_toggle(0);
        add_query();
        add_toggle(-1);
        add_query();                 // half-integer median
        add_toggle(VAL_MAX);
        add_query();
        add_toggle(5);
        add_toggle(7);
        add_toggle(0);
        add_query();
        add_toggle(-1);
        add_toggle(5);
        add_toggle(7);
        add_toggle(VAL_MIN);
        add_query();                 // empty again

        // random mix around a small set
        for (i = 0; i < 130; i++)
            if ($urandom_range(99) < 30)
                add_query();
            else
                add_toggle(pick_value());

        // fill up to capacity with distinct values, queries sprinkled in
        while (gen_member.num() < CAPACITY_DEF)
        begin
            if ($urandom_range(3) == 0)
                add_query();
            add_toggle(pick_absent());
        end

        // full set: dropped inserts, removal and re-insert, queries
        for (i = 0; i < 30; i++)
        begin
            case ($urandom_range(3))
                0: add_toggle(pick_absent());
                1: add_query();
                2:
                begin
                    v = pick_member();
                    add_toggle(v);
                    add_query();
                    add_toggle(v);
                end
                default: add_toggle(pick_value());
            endcase
        end

        // drain: mostly removals of held values
        for (i = 0; i < 120; i++)
        begin
            case ($urandom_range(3))
                0, 1: add_toggle(pick_member());
                2:    add_query();
                default: add_toggle(pick_value());
            endcase
        end
        add_query();
    endtask

    // ------------------------------------------------------------------
    // driver: a beat is taken at an edge with start high and busy low;
    // start stays up across back-to-back beats without dropping
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                update_median_set(op, value);
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() != 0 &&
                    ((accepted_count >= QUIET_LO && accepted_count < QUIET_HI) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    start <= 1'b1;
                    op    <= next_cmd.op;
                    value <= next_cmd.value;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: done is a one-cycle strobe, checked against the oldest
    // awaited result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_result = {twice_median, set_empty, was_removed, overflow, entry_count};
            result_count++;
            if (awaited_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat: twice_median=%0d count=%0d",
                             twice_median, entry_count);
            end
            else
            begin
                want_result = awaited_results.pop_front();
                if (seen_result.twice_median !== want_result.twice_median ||
                    seen_result.set_empty    !== want_result.set_empty    ||
                    seen_result.was_removed  !== want_result.was_removed  ||
                    seen_result.overflow     !== want_result.overflow     ||
                    seen_result.entry_count  !== want_result.entry_count)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("mismatch on result %0d: exp med=%0d empty=%b rm=%b ovf=%b cnt=%0d",
                                 result_count,
                                 want_result.twice_median, want_result.set_empty,
                                 want_result.was_removed, want_result.overflow,
                                 want_result.entry_count);
                        $display("    got med=%0d empty=%b rm=%b ovf=%b cnt=%0d",
                                 seen_result.twice_median, seen_result.set_empty,
                                 seen_result.was_removed, seen_result.overflow,
                                 seen_result.entry_count);
                    end
                end
                // tallies follow the predicted beat
                if (want_result.set_empty)
                    empty_count++;
                if (want_result.was_removed)
                    removed_count++;
                if (want_result.overflow)
                    overflow_count++;
                if (int'(want_result.entry_count) > peak_fill)
                    peak_fill = int'(want_result.entry_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset once, run all beats, drain, report
    // ------------------------------------------------------------------
    initial
    begin
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // every beat taken and every result back
        while (accepted_count != total_beats || awaited_results.size() != 0)
            @(posedge clk);
        // quiet tail to catch any stray result strobe
        repeat (TAIL_CYC) @(posedge clk);
        err_count += awaited_results.size();
        $display("ran %0d command beats, %0d results: %0d removals, %0d dropped inserts,",
                 total_beats, result_count, removed_count, overflow_count);
        $display("%0d empty-set queries, set filled to %0d of %0d entries",
                 empty_count, peak_fill, CAPACITY_DEF);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
